FILE: rtl/u8d_pkg.sv
// Shared types, constants and helpers for the UTF-8 byte stream decoder.
`timescale 1ns / 1ps
`default_nettype none
package u8d_pkg;

    localparam int unsigned CP_W    = 21;
    localparam int unsigned ESC_W   = 7;
    localparam int unsigned PAY_W   = 6;
    localparam int unsigned PRE_N   = 3;
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
    localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [CP_W-1:0] ESC_BASE  = 21'h00DC80;
    localparam logic [7:0]      CONT_MASK = 8'hC0;
    localparam logic [7:0]      CONT_MARK = 8'h80;

    typedef struct packed {
        logic [1:0]                       pre_cnt;
        logic [PRE_N-1:0][ESC_W-1:0]      pre;
        logic                             has_tail;
        logic [CP_W-1:0]                  tail;
    } t_cmd;

    function automatic logic [CP_W-1:0] escape_of(input logic [ESC_W-1:0] low);
        escape_of = ESC_BASE + {{(CP_W-ESC_W){1'b0}}, low};
    endfunction

    function automatic logic [1:0] lead_len(input logic [7:0] b);
        priority if (b[7:5] == 3'b110) begin
            lead_len = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            lead_len = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            lead_len = 2'd3;
        end else begin
            lead_len = 2'd0;
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/u8d_front.sv
// Front end: accepts bytes, tracks the pending sequence and builds output commands.
`timescale 1ns / 1ps
`default_nettype none
module u8d_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_end_of_stream,
    output logic                   o_push,
    output u8d_pkg::t_cmd          o_cmd,
    input  wire logic              i_q_full
);
    import u8d_pkg::*;

    logic [7:0]       r_lead;
    logic [1:0]       r_exp;
    logic [1:0]       r_rc;
    logic [PAY_W-1:0] r_store [PRE_N];

    logic [7:0]       n_lead;
    logic [1:0]       n_exp;
    logic [1:0]       n_rc;
    logic             store_we;
    logic             accept;
    logic [1:0]       len;
    logic [1:0]       rc_inc;
    t_cmd             cmd;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign len        = lead_len(i_data_byte);
    assign rc_inc     = r_rc + 2'd1;

    always_comb begin
        cmd      = '0;
        n_lead   = r_lead;
        n_exp    = r_exp;
        n_rc     = r_rc;
        store_we = 1'b0;
        if (i_end_of_stream) begin
            if (r_exp != 2'd0) begin
                cmd.pre_cnt = rc_inc;
                cmd.pre[0]  = r_lead[ESC_W-1:0];
                cmd.pre[1]  = {1'b0, r_store[0]};
                cmd.pre[2]  = {1'b0, r_store[1]};
                n_lead      = '0;
                n_exp       = '0;
                n_rc        = '0;
            end
        end else if ((r_exp != 2'd0) && ((i_data_byte & CONT_MASK) == CONT_MARK)) begin
            store_we = 1'b1;
            n_rc     = rc_inc;
            if (rc_inc == r_exp) begin
                cmd.has_tail = 1'b1;
                unique case (r_exp)
                    2'd1:    cmd.tail = {10'd0, r_lead[4:0], i_data_byte[5:0]};
                    2'd2:    cmd.tail = {5'd0, r_lead[3:0], r_store[0], i_data_byte[5:0]};
                    2'd3:    cmd.tail = {r_lead[2:0], r_store[0], r_store[1],
                                         i_data_byte[5:0]};
                    default: cmd.tail = '0;
                endcase
                n_lead = '0;
                n_exp  = '0;
                n_rc   = '0;
            end
        end else begin
            if (r_exp != 2'd0) begin
                cmd.pre_cnt = rc_inc;
                cmd.pre[0]  = r_lead[ESC_W-1:0];
                cmd.pre[1]  = {1'b0, r_store[0]};
                cmd.pre[2]  = {1'b0, r_store[1]};
                n_lead      = '0;
                n_exp       = '0;
                n_rc        = '0;
            end
            priority if (!i_data_byte[7]) begin
                cmd.has_tail = 1'b1;
                cmd.tail     = {13'd0, i_data_byte};
            end else if (len == 2'd0) begin
                cmd.has_tail = 1'b1;
                cmd.tail     = escape_of(i_data_byte[ESC_W-1:0]);
            end else begin
                n_lead = i_data_byte;
                n_exp  = len;
                n_rc   = '0;
            end
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && ((cmd.pre_cnt != 2'd0) || cmd.has_tail);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= '0;
            r_exp  <= '0;
            r_rc   <= '0;
        end else if (accept) begin
            r_lead <= n_lead;
            r_exp  <= n_exp;
            r_rc   <= n_rc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && store_we && (r_rc != 2'd3)) begin
            r_store[r_rc] <= i_data_byte[PAY_W-1:0];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/u8d_queue.sv
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module u8d_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire u8d_pkg::t_cmd     i_cmd,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output u8d_pkg::t_cmd          o_cmd
);
    import u8d_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_CW-1:0] r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/u8d_back.sv
// Back end: expands each command into output words, one per cycle while the output is not stalled.
`timescale 1ns / 1ps
`default_nettype none
module u8d_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire u8d_pkg::t_cmd     i_cmd,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [20:0]            o_code_point,
    output logic                   o_last
);
    import u8d_pkg::*;

    logic [1:0]      r_idx;
    logic            r_valid;
    logic [CP_W-1:0] r_cp;
    logic            r_last;

    logic [1:0]      n_idx;
    logic            load;
    logic            final_word;
    logic [2:0]      total;
    logic [CP_W-1:0] sel_cp;

    assign load  = i_q_valid && (!r_valid || i_out_ready);
    assign total = {1'b0, i_cmd.pre_cnt} + {2'b00, i_cmd.has_tail};
    assign final_word = ({1'b0, r_idx} == (total - 3'd1));
    assign o_pop = load && final_word;
    assign n_idx = final_word ? 2'd0 : r_idx + 2'd1;

    always_comb begin
        if (r_idx < i_cmd.pre_cnt) begin
            unique case (r_idx)
                2'd0:    sel_cp = escape_of(i_cmd.pre[0]);
                2'd1:    sel_cp = escape_of(i_cmd.pre[1]);
                2'd2:    sel_cp = escape_of(i_cmd.pre[2]);
                default: sel_cp = i_cmd.tail;
            endcase
        end else begin
            sel_cp = i_cmd.tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= n_idx;
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cp   <= sel_cp;
            r_last <= final_word;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_code_point = r_cp;
    assign o_last       = r_last;

endmodule
`default_nettype wire

FILE: rtl/utf8_byte_stream_decoder_top.sv
// Top level of the UTF-8 byte stream decoder.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready  | i_data_byte, i_end_of_stream
//  out     | output    | o_out_valid / i_out_ready| o_code_point, o_last
//
// One input word per cycle while the queue is not full; a byte causing no result is accepted the same way.
// An input word giving k results yields k output words, one word a cycle while the output
// is not stalled, produced by the back end expanding one queued command at a time.
// Reset clears the pending sequence, the two-entry queue and the output valid flag.
// Input stalls only while the queue is full; output stalls back up into the queue.
`timescale 1ns / 1ps
`default_nettype none
module utf8_byte_stream_decoder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_stream,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [20:0]      o_code_point,
    output logic             o_last
);
    import u8d_pkg::*;

    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic q_full;
    logic q_valid;
    logic pop;

    u8d_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_push          (push),
        .o_cmd           (push_cmd),
        .i_q_full        (q_full)
    );

    u8d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    u8d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_cmd        (head_cmd),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_code_point (o_code_point),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire
